### design/lfu_pkg.sv
package lfu_pkg;

	// field and register widths
	localparam int DATA_W = 32;
	localparam int CFG_W  = 5;
	localparam int APB_W  = 32;
	localparam int ADDR_W = 3;

	// access codes
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	// register word index (paddr[ADDR_W-1:2])
	localparam logic [ADDR_W-3:0] REG_ACTIVE_ENTRIES = 1'b0;

	// reset value of active_entries
	localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

	// get miss answer
	localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

	typedef struct packed {
		logic                     mode;
		logic signed [DATA_W-1:0] lookup_key;
		logic signed [DATA_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
		logic                     evicted;
		logic signed [DATA_W-1:0] evicted_key;
	} rsp_t;

endpackage

### design/lfu_stream_if.sv
interface lfu_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### design/lfu_cache_with_lru_tiebreak.sv
// Key-value cache with least-frequently-used replacement, least recent first on a tie.
// req channel (sink): one transfer carries mode (get/put), lookup_key and write_value.
// rsp channel (source): exactly one transfer per request, with hit, read_value,
//   evicted and evicted_key, in request order.
// APB port: register 0 (byte address 0) is active_entries; writing it flushes the
//   cache. The capacity used is min(active_entries, ENTRIES); zero bypasses the cache.
// A hit or a put runs from accept to response in order through one pass over the
//   entry memory to match the key and pick the victim, a decide state, a
//   read-modify-write pass updating ranks and counts, and the load of the
//   response register. A get miss skips the update pass.
//   Both passes read one entry per cycle through the one read port of the entry
//   memory. With capacity zero the request goes from idle straight to the done state.
// One request is worked on at a time; req.ready is high only while idle, so the next
//   transfer is taken at the earliest in the cycle after the response register loads.
// The response register holds a finished answer while rsp stalls; the next request
//   is still accepted and its answer waits for the register to drain.
// Reset: active_entries returns to 16, all entries invalid, no response pending.
module lfu_cache_with_lru_tiebreak #(
	parameter int ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lfu_stream_if.sink                    req,
	lfu_stream_if.source                  rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lfu_pkg::ADDR_W-1:0]    paddr,
	input  logic [lfu_pkg::APB_W-1:0]     pwdata,
	output logic [lfu_pkg::APB_W-1:0]     prdata,
	output logic                          pready
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW = IW;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int DW = lfu_pkg::DATA_W;

	typedef struct packed {
		logic [DW-1:0] key;
		logic [DW-1:0] value;
		logic [DW-1:0] count;
		logic [RW-1:0] rank;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_UPD,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic [lfu_pkg::CFG_W-1:0]    active_q;
	logic [ENTRIES-1:0]           valid_q;
	logic                         iss_q;
	logic [IW-1:0]                idx_q;
	logic                         vld_s1;
	logic [IW-1:0]                idx_s1;
	logic                         last_s1;
	logic                         out_valid_q;
	lfu_pkg::rsp_t                out_data_q;

	// request capture and pass results
	logic [DW-1:0]                key_q;
	logic [DW-1:0]                wval_q;
	logic                         put_q;
	logic [CW-1:0]                cap_q;
	logic                         found_q;
	logic [IW-1:0]                fidx_q;
	logic [DW-1:0]                fval_q;
	logic [RW-1:0]                frank_q;
	logic                         vic_q;
	logic [IW-1:0]                vidx_q;
	logic [DW-1:0]                vkey_q;
	logic [DW-1:0]                vcount_q;
	logic [RW-1:0]                vrank_q;
	logic                         free_q;
	logic [IW-1:0]                fridx_q;
	logic [CW-1:0]                used_q;
	logic                         evict_q;
	logic [IW-1:0]                tgt_q;
	logic                         upd_hit_q;
	lfu_pkg::rsp_t                pend_q;

	// entry memory
	entry_t                       entry_mem [ENTRIES];
	entry_t                       rdata_s1;
	logic                         mem_we;
	entry_t                       mem_wdata;

	logic [CW-1:0]                cap_now;
	logic                         req_xfer;
	logic                         cfg_wr;
	logic                         last_iss;
	logic                         do_evict;
	logic                         go_upd;
	logic                         s1_valid_entry;
	lfu_pkg::req_t                req_data;

	assign req_data = req.payload;

	// apb side
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[lfu_pkg::ADDR_W-1:2] == lfu_pkg::REG_ACTIVE_ENTRIES) ?
		{{(lfu_pkg::APB_W-lfu_pkg::CFG_W){1'b0}}, active_q} : '0;

	// capacity in use
	assign cap_now = (32'(active_q) >= ENTRIES) ? CW'(ENTRIES) : CW'(active_q);

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_data_q;

	assign last_iss       = (CW'(idx_q) == cap_q - CW'(1));
	assign s1_valid_entry = valid_q[idx_s1];
	assign do_evict       = vic_q && (used_q >= cap_q);
	assign go_upd         = found_q || (put_q && (do_evict || free_q));

	// sequencer, valid bits and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= lfu_pkg::ACTIVE_RESET;
			valid_q     <= '0;
			iss_q       <= 1'b0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// drain the response register unless a new answer loads this cycle
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr && paddr[lfu_pkg::ADDR_W-1:2] == lfu_pkg::REG_ACTIVE_ENTRIES) begin
				active_q <= pwdata[lfu_pkg::CFG_W-1:0];
				valid_q  <= '0;
			end

			// read issue stage
			vld_s1  <= iss_q;
			idx_s1  <= idx_q;
			last_s1 <= last_iss;
			if (iss_q) begin
				if (last_iss) begin
					iss_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (cap_now == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
							iss_q   <= 1'b1;
							idx_q   <= '0;
						end
					end
				end
				S_SCAN: begin
					if (vld_s1 && last_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (go_upd) begin
						state_q <= S_UPD;
						iss_q   <= 1'b1;
						idx_q   <= '0;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_UPD: begin
					if (vld_s1 && !upd_hit_q && idx_s1 == tgt_q) begin
						valid_q[idx_s1] <= 1'b1;
					end
					if (vld_s1 && last_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= pend_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture, scan results and pending answer
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			key_q   <= req_data.lookup_key;
			wval_q  <= req_data.write_value;
			put_q   <= (req_data.mode == lfu_pkg::MODE_PUT);
			cap_q   <= cap_now;
			found_q <= 1'b0;
			vic_q   <= 1'b0;
			free_q  <= 1'b0;
			used_q  <= '0;
			pend_q.hit         <= 1'b0;
			pend_q.read_value  <= (req_data.mode == lfu_pkg::MODE_PUT) ? '0 :
				lfu_pkg::MISS_VALUE;
			pend_q.evicted     <= 1'b0;
			pend_q.evicted_key <= '0;
		end

		// one entry per cycle: key match, victim compare, free slot
		if (state_q == S_SCAN && vld_s1) begin
			if (s1_valid_entry) begin
				used_q <= used_q + CW'(1);
				if (!found_q && rdata_s1.key == key_q) begin
					found_q <= 1'b1;
					fidx_q  <= idx_s1;
					fval_q  <= rdata_s1.value;
					frank_q <= rdata_s1.rank;
				end
				if (!vic_q || rdata_s1.count < vcount_q ||
						(rdata_s1.count == vcount_q && rdata_s1.rank > vrank_q)) begin
					vic_q    <= 1'b1;
					vidx_q   <= idx_s1;
					vkey_q   <= rdata_s1.key;
					vcount_q <= rdata_s1.count;
					vrank_q  <= rdata_s1.rank;
				end
			end else if (!free_q) begin
				free_q  <= 1'b1;
				fridx_q <= idx_s1;
			end
		end

		// pick the update pass and settle the answer
		if (state_q == S_DECIDE) begin
			upd_hit_q <= found_q;
			evict_q   <= do_evict;
			tgt_q     <= do_evict ? vidx_q : fridx_q;
			if (found_q) begin
				pend_q.hit        <= 1'b1;
				pend_q.read_value <= put_q ? '0 : fval_q;
			end else if (put_q && do_evict) begin
				pend_q.evicted     <= 1'b1;
				pend_q.evicted_key <= vkey_q;
			end
		end
	end

	// read-modify-write of one entry per cycle during the update pass
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = rdata_s1;
		if (state_q == S_UPD && vld_s1) begin
			if (upd_hit_q) begin
				if (idx_s1 == fidx_q) begin
					mem_we          = 1'b1;
					mem_wdata.value = put_q ? wval_q : rdata_s1.value;
					mem_wdata.count = (rdata_s1.count == '1) ? rdata_s1.count :
						rdata_s1.count + DW'(1);
					mem_wdata.rank  = '0;
				end else if (s1_valid_entry && rdata_s1.rank < frank_q) begin
					mem_we         = 1'b1;
					mem_wdata.rank = rdata_s1.rank + RW'(1);
				end
			end else begin
				if (idx_s1 == tgt_q) begin
					mem_we          = 1'b1;
					mem_wdata.key   = key_q;
					mem_wdata.value = wval_q;
					mem_wdata.count = DW'(1);
					mem_wdata.rank  = '0;
				end else if (s1_valid_entry) begin
					// entries behind the victim close the gap, then all move back one
					mem_we = 1'b1;
					if (!(evict_q && rdata_s1.rank > vrank_q)) begin
						mem_wdata.rank = rdata_s1.rank + RW'(1);
					end
				end
			end
		end
	end

	// entry memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[idx_s1] <= mem_wdata;
		end
		rdata_s1 <= entry_mem[idx_q];
	end

	// occupied entries never exceed the capacity in use
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) <= 32'(cap_now))
		else $error("more valid entries than capacity");

	// the entry memory is written only in the update pass
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_UPD))
		else $error("entry write outside update pass");

	// passes never touch an entry beyond the capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && (state_q == S_SCAN || state_q == S_UPD)) |-> (CW'(idx_s1) < cap_q))
		else $error("entry index beyond capacity");

	// a pending answer is never overwritten before it transfers
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> out_valid_q && $stable(out_data_q))
		else $error("response register overwritten");

endmodule
